// ===== sv/meu_pkg.sv =====
// ----------------------------------------------------------------------------
// meu_pkg: shared types and constants of the modular inverse unit
// Holds the default operand width, the modulus reset value and the command
// and status types that pass between controller and datapath.
// ----------------------------------------------------------------------------
package meu_pkg;

    localparam int VALUE_BITS_DEFAULT = 31;
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // datapath commands issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,    // capture the item, start reducing it modulo the modulus
        OP_STEP,    // one quotient bit: restoring divide and modular multiply
        OP_SETUP,   // take the reduced value as r1, set t0 to zero and t1 to one
        OP_START,   // start dividing r0 by r1
        OP_UPDATE,  // shift the remainder and coefficient pairs
        OP_RESULT   // capture the result item
    } dp_op_t;

    typedef struct packed {
        logic mod_ok;   // modulus is at least two
        logic r1_gt1;   // current remainder above one
    } dp_status_t;

endpackage

// ===== sv/modular_inverse_euclid_unit.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_euclid_unit: modular inverse by extended Euclid
// Returns value^-1 mod modulus with a no-inverse flag, one item at a time.
// ----------------------------------------------------------------------------
// Each accepted item is first reduced modulo the configured modulus, then
// extended Euclid runs on (modulus, residue) with the Bezout coefficient
// kept reduced modulo the modulus. An item passes through the reduction,
// then one full division and one update per Euclid iteration, then the
// hand-off of the result; the iteration count depends on the data (at most
// about 1.44 * N, where N is VALUE_BITS). Its run time is set by the single
// bit-serial restoring divider, which yields one quotient bit per cycle and
// feeds each bit straight into a bit-serial modular multiplier, so the
// quotient and the coefficient product finish together. The result sits in
// an output register: the next item is accepted as soon as the sequencer is
// back in idle, even while the previous result still waits to be taken.
// A zero residue, or one sharing a factor with the modulus, gives inverse 0
// with has_inverse low; a modulus below two does the same without running.
// The modulus resets to 1000000007 and may be rewritten only while idle.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_unit #(
    parameter int VALUE_BITS = meu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: modulus register
    input  logic                  cfg_we,
    input  logic [VALUE_BITS-1:0] cfg_wdata,
    // input item
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    // result item
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_inverse,
    output logic                  m_has_inverse
);
    import meu_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    // sequencer: handshakes, step counting, iteration control
    meu_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    // datapath: modulus, remainders, coefficients, divider and multiplier
    meu_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_value       (s_value),
        .op            (op),
        .status        (status),
        .m_inverse     (m_inverse),
        .m_has_inverse (m_has_inverse)
    );

endmodule

// ===== sv/meu_ctrl.sv =====
// ----------------------------------------------------------------------------
// meu_ctrl: sequencer of the modular inverse unit
// Walks the reduction, the Euclid iterations and the result hand-off, and
// owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module meu_ctrl #(
    parameter int VALUE_BITS = meu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  meu_pkg::dp_status_t status,
    output meu_pkg::dp_op_t     op
);
    import meu_pkg::*;

    localparam int CW = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        op           = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op       = OP_LOAD;
                    cnt_next = CW'(VALUE_BITS - 1);
                    state_next = status.mod_ok ? ST_REDUCE : ST_DONE;
                end
            end
            ST_REDUCE: begin
                op       = OP_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                op         = OP_SETUP;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.r1_gt1) begin
                    op         = OP_START;
                    cnt_next   = CW'(VALUE_BITS - 1);
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                op       = OP_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                op         = OP_UPDATE;
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    op           = OP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/meu_datapath.sv =====
// ----------------------------------------------------------------------------
// meu_datapath: arithmetic of the modular inverse unit
// Holds the modulus, the remainder and coefficient pairs, a bit-serial
// restoring divider and a bit-serial modular multiplier fed by the
// quotient bits as they appear, plus the result register.
// ----------------------------------------------------------------------------
module meu_datapath #(
    parameter int VALUE_BITS = meu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [VALUE_BITS-1:0]  cfg_wdata,
    input  logic [VALUE_BITS-1:0]  s_value,
    input  meu_pkg::dp_op_t        op,
    output meu_pkg::dp_status_t    status,
    output logic [VALUE_BITS-1:0]  m_inverse,
    output logic                   m_has_inverse
);
    import meu_pkg::*;

    localparam int N = VALUE_BITS;
    localparam logic [N-1:0] MOD_RST = N'(MODULUS_RESET);
    localparam logic [N-1:0] ONE     = N'(1);
    localparam logic [N-1:0] TWO     = N'(2);

    logic [N-1:0] mod_reg;
    logic [N-1:0] r0_reg, r1_reg, t0_reg, t1_reg;
    logic [N-1:0] dvd_reg, dvs_reg, rem_reg, acc_reg;
    logic [N-1:0] inv_reg;
    logic         has_reg;

    logic [N:0]   rem_sh, rem_sub;
    logic         qbit;
    logic [N-1:0] rem_next;
    logic [N:0]   dbl, dbl_sub, sum, sum_sub;
    logic [N-1:0] dbl_red, acc_next;
    logic [N-1:0] t2;

    // restoring divide: bring down one dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[N-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        qbit     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = qbit ? rem_sub[N-1:0] : rem_sh[N-1:0];
    end

    // Horner step of q * t1 mod m: double, then add t1 for a set quotient bit
    always_comb begin
        dbl      = {acc_reg, 1'b0};
        dbl_sub  = dbl - {1'b0, mod_reg};
        dbl_red  = (dbl >= {1'b0, mod_reg}) ? dbl_sub[N-1:0] : dbl[N-1:0];
        sum      = {1'b0, dbl_red} + (qbit ? {1'b0, t1_reg} : '0);
        sum_sub  = sum - {1'b0, mod_reg};
        acc_next = (sum >= {1'b0, mod_reg}) ? sum_sub[N-1:0] : sum[N-1:0];
    end

    // t0 - q*t1 mod m
    assign t2 = (t0_reg >= acc_reg) ? (t0_reg - acc_reg)
                                    : (t0_reg + (mod_reg - acc_reg));

    assign status.mod_ok = (mod_reg >= TWO);
    assign status.r1_gt1 = (r1_reg > ONE);

    assign m_inverse     = inv_reg;
    assign m_has_inverse = has_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= MOD_RST;
        end else if (cfg_we) begin
            mod_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                r0_reg  <= mod_reg;
                dvd_reg <= s_value;
                dvs_reg <= mod_reg;
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_STEP: begin
                dvd_reg <= {dvd_reg[N-2:0], 1'b0};
                rem_reg <= rem_next;
                acc_reg <= acc_next;
            end
            OP_SETUP: begin
                r1_reg <= rem_reg;
                t0_reg <= '0;
                t1_reg <= ONE;
            end
            OP_START: begin
                dvd_reg <= r0_reg;
                dvs_reg <= r1_reg;
                rem_reg <= '0;
                acc_reg <= '0;
            end
            OP_UPDATE: begin
                r0_reg <= r1_reg;
                r1_reg <= rem_reg;
                t0_reg <= t1_reg;
                t1_reg <= t2;
            end
            OP_RESULT: begin
                // a remainder of one leaves the inverse in t1; else none exists
                has_reg <= status.mod_ok && (r1_reg == ONE);
                inv_reg <= (status.mod_ok && (r1_reg == ONE)) ? t1_reg : '0;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== dv/modular_inverse_euclid_unit_tb.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_euclid_unit_tb: self-checking bench for the modular inverse
// Streams values through the unit under a series of modulus settings, works
// out each inverse and no-inverse flag with its own extended Euclid model,
// and checks every result item in order against the oldest prediction.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import meu_pkg::*;

    localparam int VB = VALUE_BITS_DEFAULT;
    // bound on the longest item: the reduction plus about 1.44*VB Euclid iterations
    localparam int ITEM_CYCLES = (VB + 2) * (VB * 3 / 2 + 2);
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int IDLE_LIMIT = 4 * (ITEM_CYCLES + HOLDOFF_CYCLES);
    localparam int DRAIN_CYCLES = 2 * (VB + 2) + 8;
    localparam int RANDOM_ITEMS = 1700;

    typedef logic [VB-1:0] word_t;

    typedef struct packed {
        word_t inverse;
        logic  has_inverse;
    } inverse_result_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  cfg_we = 1'b0;
    word_t cfg_wdata = '0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    word_t s_value = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    word_t m_inverse;
    logic  m_has_inverse;

    // pending input values, filled by the stimulus and drained by the driver
    word_t pending_values[$];
    // predicted results, oldest first
    inverse_result_t expected_inverses[$];

    word_t model_modulus = MODULUS_RESET[VB-1:0];
    int    items_queued = 0;
    int    results_seen = 0;
    int    mismatch_count = 0;
    logic  input_fired = 1'b0;

    modular_inverse_euclid_unit #(
        .VALUE_BITS(VB)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_inverse(m_inverse),
        .m_has_inverse(m_has_inverse)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: extended Euclid on (modulus, value mod modulus), keeping the
    // Bezout coefficient of the value reduced modulo the modulus. A remainder
    // of one leaves the inverse in the coefficient; zero means no inverse.
    // ------------------------------------------------------------------------
    function automatic inverse_result_t modular_inverse(input word_t value,
                                                        input word_t modulus);
        logic [63:0] rem_prev, rem_cur, rem_next, quot;
        logic [63:0] coef_prev, coef_cur, coef_next, prod;
        inverse_result_t res;
        res = '0;
        // a modulus of zero or one never divides: no inverse
        if (modulus < 2)
            return res;
        rem_prev  = 64'(modulus);
        rem_cur   = 64'(value) % 64'(modulus);
        coef_prev = '0;
        coef_cur  = 64'd1;
        while (rem_cur > 1) begin
            quot      = rem_prev / rem_cur;
            rem_next  = rem_prev - quot * rem_cur;
            prod      = ((quot % 64'(modulus)) * coef_cur) % 64'(modulus);
            coef_next = (coef_prev >= prod) ? coef_prev - prod
                                            : coef_prev + 64'(modulus) - prod;
            rem_prev  = rem_cur;
            rem_cur   = rem_next;
            coef_prev = coef_cur;
            coef_cur  = coef_next;
        end
        if (rem_cur == 1) begin
            res.inverse     = coef_cur[VB-1:0];
            res.has_inverse = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of items with random gaps. Hold valid and the value
    // until the item is taken; input_fired tells the driver that the item
    // offered at the last rising edge went in.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!s_valid || input_fired) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
                s_valid <= 1'b1;
                s_value <= pending_values.pop_front();
                if (burst_left > 0)
                    burst_left--;
                // end of burst: pick the next burst and the gap before it,
                // with back-to-back bursts about a quarter of the time
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Record accepted items and predict their results with the current modulus.
    always @(posedge aclk) begin
        if (!aresetn) begin
            input_fired <= 1'b0;
        end else begin
            input_fired <= s_valid && s_ready;
            if (s_valid && s_ready)
                expected_inverses.push_back(modular_inverse(s_value, model_modulus));
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stretches of always-ready, mostly-ready and mostly-
    // stalled, plus a long hold-off every few hundred results so the unit
    // fills up and pushes back on its input while items keep coming.
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int stall_stretch = 0;
    int holdoff_left = 0;
    int next_holdoff_at = 200;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else if (results_seen >= next_holdoff_at) begin
            holdoff_left    = HOLDOFF_CYCLES;
            next_holdoff_at = next_holdoff_at + 700;
            m_ready <= 1'b0;
        end else begin
            if (stall_stretch == 0) begin
                stall_mode    = $urandom_range(0, 2);
                stall_stretch = $urandom_range(20, 200);
            end
            stall_stretch--;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Check each result item against the oldest prediction, field by field.
    always @(posedge aclk) begin
        inverse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_inverses.size() == 0) begin
                report_mismatch($sformatf("unexpected result inverse=%0d has_inverse=%0b",
                                          m_inverse, m_has_inverse));
            end else begin
                want = expected_inverses.pop_front();
                if (m_inverse !== want.inverse)
                    report_mismatch($sformatf("inverse %0d, want %0d (result %0d)",
                                              m_inverse, want.inverse, results_seen));
                if (m_has_inverse !== want.has_inverse)
                    report_mismatch($sformatf("has_inverse %0b, want %0b (result %0d)",
                                              m_has_inverse, want.has_inverse,
                                              results_seen));
            end
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input word_t value);
        pending_values.push_back(value);
        items_queued++;
    endtask

    // wait until every queued item has produced its result
    task automatic drain();
        while (results_seen != items_queued)
            @(negedge aclk);
    endtask

    // write the modulus only once the unit has gone idle
    task automatic write_modulus(input word_t modulus);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= modulus;
        model_modulus = modulus;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic word_t pick_modulus();
        case ($urandom_range(0, 9))
            0: return word_t'(32'h7fff_ffff);
            1: return word_t'(1000000007);
            2: return word_t'(998244353);
            3: return word_t'($urandom_range(3, 64));
            4: return word_t'($urandom_range(3, 5000));
            5: return word_t'(1) << $urandom_range(2, 30);
            8: return word_t'(65537);
            9: return word_t'($urandom_range(1000, 100000) * $urandom_range(2, 7));
            default: return word_t'($urandom_range(3, 32'h7fff_ffff));
        endcase
    endfunction

    function automatic word_t pick_value(input word_t modulus);
        logic [63:0] wide;
        case ($urandom_range(0, 7))
            3: return word_t'($urandom_range(0, modulus - 1));
            4: begin
                // multiple of the modulus: reduces to zero unless it wraps
                wide = 64'(modulus) * $urandom_range(0, 3);
                return wide[VB-1:0];
            end
            5: return word_t'($urandom_range(0, 255) * $urandom_range(2, 12));
            6: return modulus + word_t'($urandom_range(0, 2)) - word_t'(1);
            7: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return word_t'(1);
                    default: return '1;
                endcase
            end
            default: return word_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: directed corners per modulus, then random phases, each with a
    // fresh modulus written while the unit is idle.
    // ------------------------------------------------------------------------
    initial begin
        word_t prime;
        word_t modulus;
        int    random_sent;
        int    phase_len;
        prime       = MODULUS_RESET[VB-1:0];
        random_sent = 0;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset modulus: zero, one, edges around the modulus, all-ones
        send_item('0);
        send_item(word_t'(1));
        send_item(word_t'(2));
        send_item(prime - word_t'(1));
        send_item(prime);
        send_item(prime + word_t'(1));
        send_item(prime + prime);
        send_item('1);
        send_item(word_t'(32'h2aaa_aaaa));
        send_item(word_t'(500000004));

        // largest modulus: a value equal to it has no inverse
        write_modulus('1);
        send_item('1);
        send_item(word_t'('1) - word_t'(1));
        send_item(word_t'(1));
        send_item(word_t'(32'h4000_0000));

        // small prime modulus
        write_modulus(word_t'(3));
        send_item('0);
        send_item(word_t'(1));
        send_item(word_t'(2));
        send_item(word_t'(5));

        // composite modulus: values sharing a factor have no inverse
        write_modulus(word_t'(1000));
        send_item(word_t'(10));
        send_item(word_t'(3));
        send_item(word_t'(999));
        send_item(word_t'(1250));

        // moduli at the bottom of the range: zero and one never run, two runs normally
        write_modulus('0);
        send_item(word_t'(5));
        write_modulus(word_t'(1));
        send_item(word_t'(7));
        write_modulus(word_t'(2));
        send_item(word_t'(3));
        send_item(word_t'(4));

        // random phases
        while (random_sent < RANDOM_ITEMS) begin
            modulus = pick_modulus();
            write_modulus(modulus);
            phase_len = $urandom_range(60, 160);
            repeat (phase_len) begin
                send_item(pick_value(modulus));
                random_sent++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_inverses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_inverses.size()));

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/meu_pkg.sv
sv/meu_ctrl.sv
sv/meu_datapath.sv
sv/modular_inverse_euclid_unit.sv
dv/modular_inverse_euclid_unit_tb.sv
